[rtl/core/saabb_pkg.sv]
package saabb_pkg;

  localparam int COORD_BITS = 24;
  localparam int SIZE_BITS  = COORD_BITS - 1;
  localparam int KIND_BITS  = 4;
  localparam int CFG_IDX_BITS = 3;

  // Working width for doubled coordinates: snapped positions and the sums
  // tested against the box edges stay well inside this range.
  localparam int DW = COORD_BITS + 5;

  localparam logic signed [DW-1:0] COORD_MAX_D =
    {{(DW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [DW-1:0] COORD_MIN_D =
    {{(DW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_SIZE_X   = 3'd3,
    REG_SIZE_Y   = 3'd4,
    REG_SIZE_Z   = 3'd5,
    REG_KIND     = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    FACE_TOP    = 3'd0,
    FACE_BOTTOM = 3'd1,
    FACE_LEFT   = 3'd2,
    FACE_RIGHT  = 3'd3,
    FACE_FRONT  = 3'd4,
    FACE_BACK   = 3'd5
  } face_e;

  localparam int NUM_FACES = 6;

  localparam face_e FACE_ORDER [NUM_FACES] = '{
    FACE_TOP, FACE_BOTTOM, FACE_LEFT, FACE_RIGHT, FACE_FRONT, FACE_BACK
  };

  // Box edges in doubled units.
  typedef struct packed {
    logic signed [DW-1:0] xl;
    logic signed [DW-1:0] xr;
    logic signed [DW-1:0] yb;
    logic signed [DW-1:0] yt;
    logic signed [DW-1:0] zf;
    logic signed [DW-1:0] zb;
    logic [KIND_BITS-1:0] kind;
  } box_t;

  // One request in flight, positions and sizes in doubled units.
  typedef struct packed {
    logic signed [DW-1:0] px;
    logic signed [DW-1:0] py;
    logic signed [DW-1:0] pz;
    logic signed [DW-1:0] ox;
    logic signed [DW-1:0] oy;
    logic signed [DW-1:0] oz;
    logic signed [DW-1:0] w;
    logic signed [DW-1:0] h2;
    logic signed [DW-1:0] d;
    logic [COORD_BITS-1:0] vel;
    logic [KIND_BITS-1:0]  kind;
    logic                  ht;
    logic                  hb;
    logic                  hx;
    logic                  hz;
  } item_t;

  function automatic item_t face_step(item_t it, box_t bx, face_e face);
    item_t r;
    logic  ovx;
    logic  ovy;
    logic  ovz;
    logic  hit;
    r   = it;
    hit = 1'b0;
    ovx = (it.px + it.w > bx.xl) && (it.px - it.w < bx.xr);
    ovy = (it.py + it.h2 > bx.yb) && (it.py < bx.yt);
    ovz = (it.pz + it.d > bx.zf) && (it.pz - it.d < bx.zb);
    case (face)
      FACE_TOP: begin
        if (it.py < bx.yt && it.oy >= bx.yt && ovx && ovz) begin
          r.py  = bx.yt;
          r.vel = '0;
          r.ht  = 1'b1;
          hit   = 1'b1;
        end
      end
      FACE_BOTTOM: begin
        if (it.py + it.h2 > bx.yb && it.oy + it.h2 <= bx.yb && ovx && ovz) begin
          r.py  = bx.yb - it.h2;
          r.vel = '0;
          r.hb  = 1'b1;
          hit   = 1'b1;
        end
      end
      FACE_LEFT: begin
        if (it.px + it.w > bx.xl && it.ox + it.w <= bx.xl && ovy && ovz) begin
          r.px = bx.xl - it.w;
          r.hx = 1'b1;
          hit  = 1'b1;
        end
      end
      FACE_RIGHT: begin
        if (it.px - it.w < bx.xr && it.ox - it.w >= bx.xr && ovy && ovz) begin
          r.px = bx.xr + it.w;
          r.hx = 1'b1;
          hit  = 1'b1;
        end
      end
      FACE_FRONT: begin
        if (it.pz + it.d > bx.zf && it.oz + it.d <= bx.zf && ovx && ovy) begin
          r.pz = bx.zf - it.d;
          r.hz = 1'b1;
          hit  = 1'b1;
        end
      end
      FACE_BACK: begin
        if (it.pz - it.d < bx.zb && it.oz - it.d >= bx.zb && ovx && ovy) begin
          r.pz = bx.zb + it.d;
          r.hz = 1'b1;
          hit  = 1'b1;
        end
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    if (hit) begin
      r.kind = bx.kind;
    end
    return r;
  endfunction

  // Halve a doubled value toward minus infinity and clamp to the coordinate range.
  function automatic logic [COORD_BITS-1:0] finish_coord(logic signed [DW-1:0] v);
    logic signed [DW-1:0] h;
    h = v >>> 1;
    if (h > COORD_MAX_D) begin
      h = COORD_MAX_D;
    end else if (h < COORD_MIN_D) begin
      h = COORD_MIN_D;
    end
    return h[COORD_BITS-1:0];
  endfunction

endpackage

[rtl/core/swept_aabb_collision_resolve.sv]
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    cur_*, prev_*, mover_*, vel_y_in, kind_in
// out      output     out_valid_o / out_stall_i  res_*, vel_y_out, hit_*, kind_out
// cfg      input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// A request is accepted every cycle unless in_stall_o is high; it passes through
// one input stage, six face-test stages (one face each) and one output stage.
// Reset clears all valid bits and the box registers; no clearing pass is needed.
// A stall on the output backs up stage by stage, filling empty stages first,
// and no request is dropped or repeated.
module swept_aabb_collision_resolve (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [saabb_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [saabb_pkg::COORD_BITS-1:0]      cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [saabb_pkg::COORD_BITS-1:0]      cur_x_i,
  input  logic [saabb_pkg::COORD_BITS-1:0]      cur_y_i,
  input  logic [saabb_pkg::COORD_BITS-1:0]      cur_z_i,
  input  logic [saabb_pkg::COORD_BITS-1:0]      prev_x_i,
  input  logic [saabb_pkg::COORD_BITS-1:0]      prev_y_i,
  input  logic [saabb_pkg::COORD_BITS-1:0]      prev_z_i,
  input  logic [saabb_pkg::SIZE_BITS-1:0]       mover_w_i,
  input  logic [saabb_pkg::SIZE_BITS-1:0]       mover_h_i,
  input  logic [saabb_pkg::SIZE_BITS-1:0]       mover_d_i,
  input  logic [saabb_pkg::COORD_BITS-1:0]      vel_y_in_i,
  input  logic [saabb_pkg::KIND_BITS-1:0]       kind_in_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [saabb_pkg::COORD_BITS-1:0]      res_x_o,
  output logic [saabb_pkg::COORD_BITS-1:0]      res_y_o,
  output logic [saabb_pkg::COORD_BITS-1:0]      res_z_o,
  output logic [saabb_pkg::COORD_BITS-1:0]      vel_y_out_o,
  output logic                                  hit_top_o,
  output logic                                  hit_bottom_o,
  output logic                                  hit_side_x_o,
  output logic                                  hit_side_z_o,
  output logic [saabb_pkg::KIND_BITS-1:0]       kind_out_o
);
  import saabb_pkg::*;

  logic [COORD_BITS-1:0] center_x_q;
  logic [COORD_BITS-1:0] center_y_q;
  logic [COORD_BITS-1:0] center_z_q;
  logic [SIZE_BITS-1:0]  size_x_q;
  logic [SIZE_BITS-1:0]  size_y_q;
  logic [SIZE_BITS-1:0]  size_z_q;
  logic [KIND_BITS-1:0]  kind_q;
  box_t                  box_d;
  box_t                  box_q;

  logic  prep_ready;
  logic  prep_valid;
  item_t prep_item;
  logic  faces_ready;
  logic  faces_valid;
  item_t faces_item;
  logic  fin_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
      size_x_q   <= '0;
      size_y_q   <= '0;
      size_z_q   <= '0;
      kind_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_CENTER_X: center_x_q <= cfg_data_i;
        REG_CENTER_Y: center_y_q <= cfg_data_i;
        REG_CENTER_Z: center_z_q <= cfg_data_i;
        REG_SIZE_X:   size_x_q   <= cfg_data_i[SIZE_BITS-1:0];
        REG_SIZE_Y:   size_y_q   <= cfg_data_i[SIZE_BITS-1:0];
        REG_SIZE_Z:   size_z_q   <= cfg_data_i[SIZE_BITS-1:0];
        REG_KIND:     kind_q     <= cfg_data_i[KIND_BITS-1:0];
        default: begin
          kind_q <= kind_q;
        end
      endcase
    end
  end

  function automatic logic signed [DW-1:0] dbl(logic [COORD_BITS-1:0] c);
    return {{(DW-COORD_BITS-1){c[COORD_BITS-1]}}, c, 1'b0};
  endfunction

  function automatic logic signed [DW-1:0] usz(logic [SIZE_BITS-1:0] s);
    return {{(DW-SIZE_BITS){1'b0}}, s};
  endfunction

  // Box edges are registered once from the settings; in doubled units the
  // half size is the full size, so every edge is exact.
  always_comb begin
    box_d.xl   = dbl(center_x_q) - usz(size_x_q);
    box_d.xr   = dbl(center_x_q) + usz(size_x_q);
    box_d.yb   = dbl(center_y_q) - usz(size_y_q);
    box_d.yt   = dbl(center_y_q) + usz(size_y_q);
    box_d.zf   = dbl(center_z_q) - usz(size_z_q);
    box_d.zb   = dbl(center_z_q) + usz(size_z_q);
    box_d.kind = kind_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= '0;
    end else begin
      box_q <= box_d;
    end
  end

  assign in_stall_o = !prep_ready;

  saabb_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_i),
    .ready_o    (prep_ready),
    .cur_x_i    (cur_x_i),
    .cur_y_i    (cur_y_i),
    .cur_z_i    (cur_z_i),
    .prev_x_i   (prev_x_i),
    .prev_y_i   (prev_y_i),
    .prev_z_i   (prev_z_i),
    .mover_w_i  (mover_w_i),
    .mover_h_i  (mover_h_i),
    .mover_d_i  (mover_d_i),
    .vel_y_in_i (vel_y_in_i),
    .kind_in_i  (kind_in_i),
    .valid_o    (prep_valid),
    .item_o     (prep_item),
    .ready_i    (faces_ready)
  );

  saabb_faces u_faces (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .box_i   (box_q),
    .valid_i (prep_valid),
    .ready_o (faces_ready),
    .item_i  (prep_item),
    .valid_o (faces_valid),
    .item_o  (faces_item),
    .ready_i (fin_ready)
  );

  saabb_finish u_finish (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (faces_valid),
    .ready_o      (fin_ready),
    .item_i       (faces_item),
    .valid_o      (out_valid_o),
    .ready_i      (!out_stall_i),
    .res_x_o      (res_x_o),
    .res_y_o      (res_y_o),
    .res_z_o      (res_z_o),
    .vel_y_out_o  (vel_y_out_o),
    .hit_top_o    (hit_top_o),
    .hit_bottom_o (hit_bottom_o),
    .hit_side_x_o (hit_side_x_o),
    .hit_side_z_o (hit_side_z_o),
    .kind_out_o   (kind_out_o)
  );

endmodule

[rtl/core/saabb_prep.sv]
module saabb_prep (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic [saabb_pkg::COORD_BITS-1:0]   cur_x_i,
  input  logic [saabb_pkg::COORD_BITS-1:0]   cur_y_i,
  input  logic [saabb_pkg::COORD_BITS-1:0]   cur_z_i,
  input  logic [saabb_pkg::COORD_BITS-1:0]   prev_x_i,
  input  logic [saabb_pkg::COORD_BITS-1:0]   prev_y_i,
  input  logic [saabb_pkg::COORD_BITS-1:0]   prev_z_i,
  input  logic [saabb_pkg::SIZE_BITS-1:0]    mover_w_i,
  input  logic [saabb_pkg::SIZE_BITS-1:0]    mover_h_i,
  input  logic [saabb_pkg::SIZE_BITS-1:0]    mover_d_i,
  input  logic [saabb_pkg::COORD_BITS-1:0]   vel_y_in_i,
  input  logic [saabb_pkg::KIND_BITS-1:0]    kind_in_i,
  output logic                               valid_o,
  output saabb_pkg::item_t                   item_o,
  input  logic                               ready_i
);
  import saabb_pkg::*;

  logic  valid_q;
  item_t item_q;
  item_t item_d;

  function automatic logic signed [DW-1:0] dbl(logic [COORD_BITS-1:0] c);
    return {{(DW-COORD_BITS-1){c[COORD_BITS-1]}}, c, 1'b0};
  endfunction

  function automatic logic signed [DW-1:0] usz(logic [SIZE_BITS-1:0] s);
    return {{(DW-SIZE_BITS){1'b0}}, s};
  endfunction

  always_comb begin
    item_d.px   = dbl(cur_x_i);
    item_d.py   = dbl(cur_y_i);
    item_d.pz   = dbl(cur_z_i);
    item_d.ox   = dbl(prev_x_i);
    item_d.oy   = dbl(prev_y_i);
    item_d.oz   = dbl(prev_z_i);
    item_d.w    = usz(mover_w_i);
    item_d.h2   = {{(DW-SIZE_BITS-1){1'b0}}, mover_h_i, 1'b0};
    item_d.d    = usz(mover_d_i);
    item_d.vel  = vel_y_in_i;
    item_d.kind = kind_in_i;
    item_d.ht   = 1'b0;
    item_d.hb   = 1'b0;
    item_d.hx   = 1'b0;
    item_d.hz   = 1'b0;
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

[rtl/core/saabb_faces.sv]
module saabb_faces (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  saabb_pkg::box_t   box_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  saabb_pkg::item_t  item_i,
  output logic              valid_o,
  output saabb_pkg::item_t  item_o,
  input  logic              ready_i
);
  import saabb_pkg::*;

  logic  [NUM_FACES-1:0] valid_q;
  logic  [NUM_FACES:0]   rdy;
  item_t                 item_q [NUM_FACES];

  assign rdy[NUM_FACES] = ready_i;
  assign ready_o        = rdy[0];
  assign valid_o        = valid_q[NUM_FACES-1];
  assign item_o         = item_q[NUM_FACES-1];

  // One face test per stage, in the fixed order top, bottom, left, right, front, back.
  for (genvar k = 0; k < NUM_FACES; k++) begin : g_face
    item_t stg_in;
    item_t stg_d;
    logic  stg_valid_in;

    if (k == 0) begin : g_first
      assign stg_in       = item_i;
      assign stg_valid_in = valid_i;
    end else begin : g_next
      assign stg_in       = item_q[k-1];
      assign stg_valid_in = valid_q[k-1];
    end

    assign stg_d  = face_step(stg_in, box_i, FACE_ORDER[k]);
    assign rdy[k] = !valid_q[k] || rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_q[k] <= stg_valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && stg_valid_in) begin
        item_q[k] <= stg_d;
      end
    end
  end

endmodule

[rtl/core/saabb_finish.sv]
module saabb_finish (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  saabb_pkg::item_t                  item_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic [saabb_pkg::COORD_BITS-1:0]  res_x_o,
  output logic [saabb_pkg::COORD_BITS-1:0]  res_y_o,
  output logic [saabb_pkg::COORD_BITS-1:0]  res_z_o,
  output logic [saabb_pkg::COORD_BITS-1:0]  vel_y_out_o,
  output logic                              hit_top_o,
  output logic                              hit_bottom_o,
  output logic                              hit_side_x_o,
  output logic                              hit_side_z_o,
  output logic [saabb_pkg::KIND_BITS-1:0]   kind_out_o
);
  import saabb_pkg::*;

  logic                  valid_q;
  logic [COORD_BITS-1:0] res_x_q;
  logic [COORD_BITS-1:0] res_y_q;
  logic [COORD_BITS-1:0] res_z_q;
  logic [COORD_BITS-1:0] vel_q;
  logic [3:0]            flags_q;
  logic [KIND_BITS-1:0]  kind_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_x_q <= finish_coord(item_i.px);
      res_y_q <= finish_coord(item_i.py);
      res_z_q <= finish_coord(item_i.pz);
      vel_q   <= item_i.vel;
      flags_q <= {item_i.ht, item_i.hb, item_i.hx, item_i.hz};
      kind_q  <= item_i.kind;
    end
  end

  assign res_x_o      = res_x_q;
  assign res_y_o      = res_y_q;
  assign res_z_o      = res_z_q;
  assign vel_y_out_o  = vel_q;
  assign hit_top_o    = flags_q[3];
  assign hit_bottom_o = flags_q[2];
  assign hit_side_x_o = flags_q[1];
  assign hit_side_z_o = flags_q[0];
  assign kind_out_o   = kind_q;

endmodule

[verif/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import saabb_pkg::*;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [SIZE_BITS-1:0]  size_t;
  typedef logic [KIND_BITS-1:0]  kind_t;

  typedef struct packed {
    coord_t cur_x;
    coord_t cur_y;
    coord_t cur_z;
    coord_t prev_x;
    coord_t prev_y;
    coord_t prev_z;
    size_t  w;
    size_t  h;
    size_t  d;
    coord_t vel;
    kind_t  kind;
  } request_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    coord_t vel;
    logic   top;
    logic   bottom;
    logic   side_x;
    logic   side_z;
    kind_t  kind;
  } result_t;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = '1;
  localparam longint COORD_HI = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam longint COORD_LO = -COORD_HI - 1;

  function automatic longint wide(coord_t v);
    return longint'($signed(v));
  endfunction

  function automatic coord_t to_coord(longint v);
    if (v > COORD_HI) begin
      v = COORD_HI;
    end else if (v < COORD_LO) begin
      v = COORD_LO;
    end
    return coord_t'(v);
  endfunction

  class collision_scoreboard;
    coord_t  center_x;
    coord_t  center_y;
    coord_t  center_z;
    size_t   size_x;
    size_t   size_y;
    size_t   size_z;
    kind_t   box_kind;
    result_t resolved_q[$];
    int      mismatches;

    function new();
      center_x   = '0;
      center_y   = '0;
      center_z   = '0;
      size_x     = '0;
      size_y     = '0;
      size_z     = '0;
      box_kind   = '0;
      mismatches = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_BITS-1:0] idx, coord_t data);
      case (idx)
        REG_CENTER_X: center_x = data;
        REG_CENTER_Y: center_y = data;
        REG_CENTER_Z: center_z = data;
        REG_SIZE_X:   size_x   = data[SIZE_BITS-1:0];
        REG_SIZE_Y:   size_y   = data[SIZE_BITS-1:0];
        REG_SIZE_Z:   size_z   = data[SIZE_BITS-1:0];
        REG_KIND:     box_kind = data[KIND_BITS-1:0];
        default: begin
        end
      endcase
    endfunction

    // Strict overlap of a span centered at p with half extent hw (doubled units).
    function bit overlap(longint p, longint hw, longint lo, longint hi);
      return (p + hw > lo) && (p - hw < hi);
    endfunction

    function coord_t halve_sat(longint v);
      return to_coord(v >>> 1);
    endfunction

    // All positions are doubled so the half sizes stay exact.
    function result_t resolve(request_t r);
      longint  px, py, pz, ox, oy, oz;
      longint  w, h, h2, d;
      longint  xl, xr, yb, yt, zf, zb;
      result_t q;
      px = 2 * wide(r.cur_x);
      py = 2 * wide(r.cur_y);
      pz = 2 * wide(r.cur_z);
      ox = 2 * wide(r.prev_x);
      oy = 2 * wide(r.prev_y);
      oz = 2 * wide(r.prev_z);
      w  = longint'(r.w);
      h  = longint'(r.h);
      h2 = 2 * h;
      d  = longint'(r.d);
      xl = 2 * wide(center_x) - longint'(size_x);
      xr = 2 * wide(center_x) + longint'(size_x);
      yb = 2 * wide(center_y) - longint'(size_y);
      yt = 2 * wide(center_y) + longint'(size_y);
      zf = 2 * wide(center_z) - longint'(size_z);
      zb = 2 * wide(center_z) + longint'(size_z);
      q = '0;
      q.vel  = r.vel;
      q.kind = r.kind;

      if (py < yt && oy >= yt && overlap(px, w, xl, xr) && overlap(pz, d, zf, zb)) begin
        py     = yt;
        q.vel  = '0;
        q.top  = 1'b1;
      end
      if (py + h2 > yb && oy + h2 <= yb && overlap(px, w, xl, xr) &&
          overlap(pz, d, zf, zb)) begin
        py       = yb - h2;
        q.vel    = '0;
        q.bottom = 1'b1;
      end
      if (px + w > xl && ox + w <= xl && overlap(py + h, h, yb, yt) &&
          overlap(pz, d, zf, zb)) begin
        px       = xl - w;
        q.side_x = 1'b1;
      end
      if (px - w < xr && ox - w >= xr && overlap(py + h, h, yb, yt) &&
          overlap(pz, d, zf, zb)) begin
        px       = xr + w;
        q.side_x = 1'b1;
      end
      if (pz + d > zf && oz + d <= zf && overlap(px, w, xl, xr) &&
          overlap(py + h, h, yb, yt)) begin
        pz       = zf - d;
        q.side_z = 1'b1;
      end
      if (pz - d < zb && oz - d >= zb && overlap(px, w, xl, xr) &&
          overlap(py + h, h, yb, yt)) begin
        pz       = zb + d;
        q.side_z = 1'b1;
      end

      if (q.top || q.bottom || q.side_x || q.side_z) begin
        q.kind = box_kind;
      end
      q.x = halve_sat(px);
      q.y = halve_sat(py);
      q.z = halve_sat(pz);
      return q;
    endfunction

    function void note_request(request_t r);
      resolved_q.push_back(resolve(r));
    endfunction

    function int pending();
      return resolved_q.size();
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, coord_t got, coord_t want);
      if (got !== want) begin
        report($sformatf("%s got %h expected %h", name, got, want));
      end
    endtask

    task check_result(result_t got);
      result_t want;
      if (resolved_q.size() == 0) begin
        report("result arrived with no request outstanding");
      end else begin
        want = resolved_q.pop_front();
        compare_field("res_x", got.x, want.x);
        compare_field("res_y", got.y, want.y);
        compare_field("res_z", got.z, want.z);
        compare_field("vel_y_out", got.vel, want.vel);
        compare_field("hit_top", coord_t'(got.top), coord_t'(want.top));
        compare_field("hit_bottom", coord_t'(got.bottom), coord_t'(want.bottom));
        compare_field("hit_side_x", coord_t'(got.side_x), coord_t'(want.side_x));
        compare_field("hit_side_z", coord_t'(got.side_z), coord_t'(want.side_z));
        compare_field("kind_out", coord_t'(got.kind), coord_t'(want.kind));
      end
    endtask
  endclass

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx = '0;
  coord_t   cfg_data  = '0;
  logic     in_valid  = 1'b0;
  request_t in_req    = '0;
  logic     out_stall = 1'b0;

  logic     in_stall;
  logic     out_valid;
  coord_t   res_x, res_y, res_z, vel_y_out;
  logic     hit_top, hit_bottom, hit_side_x, hit_side_z;
  kind_t    kind_out;

  int send_idle_pct = 0;
  int stall_pct     = 0;

  collision_scoreboard sb;

  swept_aabb_collision_resolve uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .cur_x_i      (in_req.cur_x),
    .cur_y_i      (in_req.cur_y),
    .cur_z_i      (in_req.cur_z),
    .prev_x_i     (in_req.prev_x),
    .prev_y_i     (in_req.prev_y),
    .prev_z_i     (in_req.prev_z),
    .mover_w_i    (in_req.w),
    .mover_h_i    (in_req.h),
    .mover_d_i    (in_req.d),
    .vel_y_in_i   (in_req.vel),
    .kind_in_i    (in_req.kind),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .res_x_o      (res_x),
    .res_y_o      (res_y),
    .res_z_o      (res_z),
    .vel_y_out_o  (vel_y_out),
    .hit_top_o    (hit_top),
    .hit_bottom_o (hit_bottom),
    .hit_side_x_o (hit_side_x),
    .hit_side_z_o (hit_side_z),
    .kind_out_o   (kind_out)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_request(in_req);
    end
  end

  always @(posedge clk) begin : result_monitor
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.x      = res_x;
      got.y      = res_y;
      got.z      = res_z;
      got.vel    = vel_y_out;
      got.top    = hit_top;
      got.bottom = hit_bottom;
      got.side_x = hit_side_x;
      got.side_z = hit_side_z;
      got.kind   = kind_out;
      sb.check_result(got);
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL swept_aabb_collision_resolve");
    $finish;
  end

  function automatic request_t mk(coord_t cx, coord_t cy, coord_t cz, coord_t ox,
                                  coord_t oy, coord_t oz, size_t w, size_t h,
                                  size_t d, coord_t vel, kind_t kind);
    request_t r;
    r.cur_x  = cx;
    r.cur_y  = cy;
    r.cur_z  = cz;
    r.prev_x = ox;
    r.prev_y = oy;
    r.prev_z = oz;
    r.w      = w;
    r.h      = h;
    r.d      = d;
    r.vel    = vel;
    r.kind   = kind;
    return r;
  endfunction

  function automatic size_t pick_size();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      2:       return size_t'($urandom);
      default: return size_t'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic coord_t near_zero(int span);
    return coord_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Offset from the box center along one axis, weighted toward the edges
  // where the mover just touches the face.
  function automatic longint near_offset(longint e);
    longint m;
    m = e / 4 + 4;
    case ($urandom_range(7))
      0:       return e;
      1:       return -e;
      2:       return e + 1;
      3:       return -e - 1;
      default: return longint'($urandom_range(0, 32'(2 * (e + m)))) - (e + m);
    endcase
  endfunction

  // A request placed around the current box. When aimed, the mover sits
  // inside the box and came from outside the chosen face.
  function automatic request_t aimed_request(bit aimed, face_e face);
    request_t r;
    longint   base [3];
    longint   e [3];
    longint   co [3];
    longint   po [3];
    int       ax;
    bit       up;
    r.w = pick_size();
    r.h = pick_size();
    r.d = pick_size();
    base[0] = wide(sb.center_x);
    base[1] = wide(sb.center_y) - longint'(r.h) / 2;
    base[2] = wide(sb.center_z);
    e[0] = (longint'(sb.size_x) + longint'(r.w)) / 2;
    e[1] = (longint'(sb.size_y) + longint'(r.h)) / 2;
    e[2] = (longint'(sb.size_z) + longint'(r.d)) / 2;
    ax = 0;
    up = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (aimed) begin
        co[a] = longint'($urandom_range(0, 32'(e[a]))) - e[a] / 2;
        po[a] = co[a];
      end else begin
        co[a] = near_offset(e[a]);
        case ($urandom_range(3))
          0:       po[a] = co[a];
          1:       po[a] = -co[a];
          default: po[a] = near_offset(e[a]);
        endcase
      end
    end
    if (aimed) begin
      case (face)
        FACE_TOP:    begin ax = 1; up = 1'b1; end
        FACE_BOTTOM: begin ax = 1; up = 1'b0; end
        FACE_LEFT:   begin ax = 0; up = 1'b0; end
        FACE_RIGHT:  begin ax = 0; up = 1'b1; end
        FACE_FRONT:  begin ax = 2; up = 1'b0; end
        default:     begin ax = 2; up = 1'b1; end
      endcase
      po[ax] = e[ax] + 1 + longint'($urandom_range(0, 32'(e[ax] / 2 + 2)));
      if (!up) begin
        po[ax] = -po[ax];
      end
    end
    r.cur_x  = to_coord(base[0] + co[0]);
    r.cur_y  = to_coord(base[1] + co[1]);
    r.cur_z  = to_coord(base[2] + co[2]);
    r.prev_x = to_coord(base[0] + po[0]);
    r.prev_y = to_coord(base[1] + po[1]);
    r.prev_z = to_coord(base[2] + po[2]);
    r.vel    = coord_t'($urandom);
    r.kind   = kind_t'($urandom);
    return r;
  endfunction

  task automatic send(request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold off new requests until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, coord_t data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    sb.apply_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic load_box(coord_t cx, coord_t cy, coord_t cz, coord_t sx, coord_t sy,
                          coord_t sz, coord_t kd);
    cfg_write(REG_CENTER_X, cx);
    cfg_write(REG_CENTER_Y, cy);
    cfg_write(REG_CENTER_Z, cz);
    cfg_write(REG_SIZE_X, sx);
    cfg_write(REG_SIZE_Y, sy);
    cfg_write(REG_SIZE_Z, sz);
    cfg_write(REG_KIND, kd);
    cfg_write(REG_UNUSED, coord_t'($urandom));
    cfg_we <= 1'b0;
  endtask

  initial begin
    request_t r;
    int       n;
    int       k;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset box: all zero. Extremes and hits on a zero-size box.
    send('0);
    send(mk('1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1, '1, '1,
            '1 >> 1, '1));
    send(mk(24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000,
            '0, '0, '0, 24'h800000, '0));
    send(mk('0, '1, '0, '0, 24'h000001, '0, '1, '1, '1, 24'h000123, 4'h5));
    send(mk('0, 24'h000001, '0, '0, '1, '0, '1, '0, '1, 24'h7FF000, 4'hA));
    send(mk(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000,
            '1, '1, '1, 24'h000040, 4'h3));
    send(mk(24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
            '1, '1, '1, 24'hFFFFC0, 4'hC));
    drain();

    // Odd box sizes put snapped faces on half steps; high bits above the
    // register widths must be dropped.
    load_box(24'd1000, -24'sd2000, 24'd300, 24'h800259, 24'd401, 24'd255, 24'hFFFFF9);
    for (int f = 0; f < NUM_FACES; f++) begin
      repeat (2) send(aimed_request(1'b1, FACE_ORDER[3'(f)]));
    end
    drain();

    n = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1: load_box(near_zero(65536), near_zero(65536), near_zero(65536), '0, '0, '0,
                    24'hF);
        2: load_box(24'h7FFFFF, 24'h800000, '0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                    24'hF);
        3: load_box(24'h800000, 24'h7FFFFF, near_zero(4096),
                    coord_t'($urandom_range(0, 4095) | 1),
                    coord_t'($urandom_range(0, 4095) | 1),
                    coord_t'($urandom_range(0, 4095) | 1), '0);
        4: load_box(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                    coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                    coord_t'($urandom));
        default: load_box(near_zero(65536), near_zero(65536), near_zero(65536),
                          coord_t'($urandom_range(1, 8192)),
                          coord_t'($urandom_range(1, 8192)),
                          coord_t'($urandom_range(1, 8192)),
                          coord_t'($urandom_range(15)));
      endcase
      for (int i = 0; i < 250; i++) begin
        if (n < 700) begin
          send_idle_pct = 35;
          stall_pct     = 62;
        end else if (n < 1400) begin
          send_idle_pct = 62;
          stall_pct     = 35;
        end else begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        if (n % 500 == 499) begin
          drain();
        end
        k = $urandom_range(9);
        if (k == 0) begin
          r = mk(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                 coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                 size_t'($urandom), size_t'($urandom), size_t'($urandom),
                 coord_t'($urandom), kind_t'($urandom));
        end else if (k == 1) begin
          r = aimed_request(1'b1, FACE_ORDER[3'($urandom_range(NUM_FACES - 1))]);
        end else begin
          r = aimed_request(1'b0, FACE_TOP);
        end
        send(r);
        n++;
      end
      drain();
    end

    if (sb.mismatches == 0) begin
      $display("PASS swept_aabb_collision_resolve");
    end else begin
      $display("FAIL swept_aabb_collision_resolve");
    end
    $finish;
  end

endmodule
